[hw/rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [31:0] CP_MAX        = 32'h0010_ffff;
	localparam logic [31:0] BMP_MAX       = 32'h0000_ffff;
	localparam logic [31:0] SURR_LO_BOUND = 32'h0000_d800;
	localparam logic [31:0] SURR_HI_BOUND = 32'h0000_e000;
	localparam logic [20:0] SUPP_OFFSET   = 21'h01_0000;
	localparam logic [20:0] HI_SURR_BASE  = 21'h00_d800;
	localparam logic [20:0] LO_SURR_BASE  = 21'h00_dc00;
	localparam logic [7:0]  CONT_TAG_MASK = 8'hc0;
	localparam logic [7:0]  CONT_TAG      = 8'h80;

	typedef struct packed {
		logic        pair;
		logic [20:0] cp;
	} cmd_t;

endpackage

[hw/rtl/u8d_front.sv]
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, keeps the code point accumulator and turns each completed
// character up to CP_MAX into a back-end command; surrogates need wide_units.
// ----------------------------------------------------------------------------
module u8d_front
	import u8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wide_units,
	input  logic       accept,
	input  logic [7:0] byte_req,
	input  logic [7:0] next_byte,
	output logic       push,
	output cmd_t       cmd
);

	logic [31:0] acc_q;
	logic [31:0] acc_d;
	logic        emit;
	logic        surrogate;

	always_comb begin
		case (byte_req) inside
			[8'h00:8'h7f]: acc_d = {24'b0, byte_req};
			[8'h80:8'hbf]: acc_d = {acc_q[25:0], byte_req[5:0]};
			[8'hc0:8'hdf]: acc_d = {27'b0, byte_req[4:0]};
			[8'he0:8'hef]: acc_d = {28'b0, byte_req[3:0]};
			default:       acc_d = {29'b0, byte_req[2:0]};
		endcase
	end

	assign emit      = ((next_byte & CONT_TAG_MASK) != CONT_TAG) && (acc_d <= CP_MAX);
	assign surrogate = (acc_d >= SURR_LO_BOUND) && (acc_d < SURR_HI_BOUND);

	assign cmd.pair = !wide_units && (acc_d > BMP_MAX);
	assign cmd.cp   = acc_d[20:0];
	assign push     = accept && emit && (wide_units || !surrogate);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'b0;
		end else if (accept) begin
			acc_q <= acc_d;
		end
	end

endmodule

[hw/rtl/u8d_queue.sv]
// ----------------------------------------------------------------------------
// u8d_queue
// Small first-word-fall-through queue of decoded commands.
// ----------------------------------------------------------------------------
module u8d_queue
	import u8d_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/u8d_back.sv]
// ----------------------------------------------------------------------------
// u8d_back
// Turns queued commands into code units, splitting commands marked as a
// pair into a surrogate pair, and holds the output register.
// ----------------------------------------------------------------------------
module u8d_back
	import u8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head_cmd,
	input  logic        empty,
	output logic        pop,
	input  logic        unit_stall,
	output logic        unit_valid,
	output logic [20:0] code_unit,
	output logic        last_unit
);

	logic        out_valid_q;
	logic [20:0] code_unit_q;
	logic        last_unit_q;
	logic        half_q;
	logic        slot_free;
	logic        load;
	logic [20:0] supp;
	logic [20:0] hi_unit;
	logic [20:0] lo_unit;

	assign slot_free = !out_valid_q || !unit_stall;
	assign load      = slot_free && !empty;
	assign pop       = load && (!head_cmd.pair || half_q);

	assign supp    = head_cmd.cp - SUPP_OFFSET;
	assign hi_unit = HI_SURR_BASE + {11'b0, supp[19:10]};
	assign lo_unit = LO_SURR_BASE + {11'b0, supp[9:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			half_q      <= head_cmd.pair && !half_q;
		end else if (slot_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (!head_cmd.pair) begin
				code_unit_q <= head_cmd.cp;
				last_unit_q <= 1'b1;
			end else if (!half_q) begin
				code_unit_q <= hi_unit;
				last_unit_q <= 1'b0;
			end else begin
				code_unit_q <= lo_unit;
				last_unit_q <= 1'b1;
			end
		end
	end

	assign unit_valid = out_valid_q;
	assign code_unit  = code_unit_q;
	assign last_unit  = last_unit_q;

`ifndef SYNTHESIS
	a_half_shows_high: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> out_valid_q && !last_unit_q)
		else $error("pending low surrogate without a high surrogate shown");

	a_high_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_unit_q |-> code_unit_q[20:10] == 11'h036)
		else $error("non-final unit is not a high surrogate");

	a_low_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_unit_q && !unit_stall |=> out_valid_q && last_unit_q)
		else $error("low surrogate does not follow high surrogate");

	a_pop_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && last_unit_q)
		else $error("command retired without its final unit");
`endif

endmodule

[hw/rtl/utf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streams UTF-8 bytes with a one-byte lookahead into code points or
// UTF-16 code units.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the command queue has room. A
// completed character passes the command queue and the output register and
// leaves as one unit or as a surrogate pair. A supplementary character
// takes four input bytes and yields at most two units, so the byte side
// keeps one byte per cycle while the output is not stalled. The queue of
// QUEUE_DEPTH commands absorbs output stalls before the byte side stalls.
// The user must write wide_units only while the block is idle; not enforced.
module utf8_to_utf16_decoder
	import u8d_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wide_units_we,
	input  logic        wide_units_wdata,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_req,
	input  logic [7:0]  next_byte,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [20:0] code_unit,
	output logic        last_unit
);

	logic wide_units_q;
	logic accept;
	logic push;
	cmd_t push_cmd;
	cmd_t head_cmd;
	logic full;
	logic empty;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_units_q <= 1'b0;
		end else if (wide_units_we) begin
			wide_units_q <= wide_units_wdata;
		end
	end

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wide_units (wide_units_q),
		.accept     (accept),
		.byte_req   (byte_req),
		.next_byte  (next_byte),
		.push       (push),
		.cmd        (push_cmd)
	);

	u8d_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (full),
		.empty    (empty)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.empty      (empty),
		.pop        (pop),
		.unit_stall (unit_stall),
		.unit_valid (unit_valid),
		.code_unit  (code_unit),
		.last_unit  (last_unit)
	);

endmodule
